[rtl/core/assert_macros.svh]
// Assertion macros shared by the heading tracker RTL.
// Expects clk and rst_n (synchronous, active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle outside reset.
`define RLHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RLHT_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/rlht_pkg.sv]
// Package for the rate limited heading tracker: widths, constants, CORDIC table.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package rlht_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 12;

  localparam int TABLE_LEN = 24;
  localparam int TAB_IDX_W = 5;
  localparam int NUM_IT    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CNT_W     = (NUM_IT > 1) ? $clog2(NUM_IT) : 1;

  localparam int POS_W      = 12;
  localparam int DT_W       = 12;
  localparam int HEAD_W     = 16;
  localparam int RATE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // CORDIC vector: coordinate difference times 2^VEC_SHIFT, sign and gain headroom
  localparam int VEC_SHIFT = 16;
  localparam int XY_W      = COORD_BITS + VEC_SHIFT + 3;
  localparam int Z_W       = 26;
  localparam int ATAN_W    = 21;
  localparam int BRAW_W    = 17;
  localparam int RND_SHIFT = 8;

  localparam int FULL_TURN = 46080;
  localparam int HALF_TURN = 23040;
  localparam int WRAP_BIAS = 8 * FULL_TURN;
  localparam int Z_HALF    = 5898240;
  localparam int Z_FULL    = 11796480;
  localparam int Z_RND     = 128;
  localparam int FRAC_BITS = 7;

  // floor(p / 1000) = (p * RECIP) >> RECIP_SHIFT, exact for p < 2^28
  localparam int MUL_A_W     = 28;
  localparam int MUL_B_W     = 29;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RECIP       = 274877907;
  localparam int RECIP_SHIFT = 38;
  localparam int STEP_W      = 18;
  localparam int ACC_W       = 19;

  localparam int CENTER_X_RST = 400;
  localparam int CENTER_Y_RST = 300;
  localparam int MAX_RATE_RST = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_MAX_RATE = 2'd2
  } reg_idx_t;

  // atan(2^-i) in units of 2^-15 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = ATAN_W'(1474560);
      5'd1:    v = ATAN_W'(870484);
      5'd2:    v = ATAN_W'(459940);
      5'd3:    v = ATAN_W'(233473);
      5'd4:    v = ATAN_W'(117189);
      5'd5:    v = ATAN_W'(58652);
      5'd6:    v = ATAN_W'(29333);
      5'd7:    v = ATAN_W'(14667);
      5'd8:    v = ATAN_W'(7334);
      5'd9:    v = ATAN_W'(3667);
      5'd10:   v = ATAN_W'(1833);
      5'd11:   v = ATAN_W'(917);
      5'd12:   v = ATAN_W'(458);
      5'd13:   v = ATAN_W'(229);
      5'd14:   v = ATAN_W'(115);
      5'd15:   v = ATAN_W'(57);
      5'd16:   v = ATAN_W'(29);
      5'd17:   v = ATAN_W'(14);
      5'd18:   v = ATAN_W'(7);
      5'd19:   v = ATAN_W'(4);
      5'd20:   v = ATAN_W'(2);
      5'd21:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/rlht_in_if.sv]
// Input channel of the heading tracker: target point and elapsed time.
// Depends on rlht_pkg for field widths.
`timescale 1ns / 1ps

interface rlht_in_if;
  logic                       valid;
  logic                       ready;
  logic [rlht_pkg::POS_W-1:0] target_x;
  logic [rlht_pkg::POS_W-1:0] target_y;
  logic [rlht_pkg::DT_W-1:0]  elapsed_ms;

  modport source(output valid, output target_x, output target_y, output elapsed_ms,
                 input ready);
  modport sink(input valid, input target_x, input target_y, input elapsed_ms,
               output ready);
endinterface

[rtl/core/rlht_out_if.sv]
// Result channel of the heading tracker: new heading in 1/128 degree.
// Depends on rlht_pkg for field widths.
`timescale 1ns / 1ps

interface rlht_out_if;
  logic                        valid;
  logic                        ready;
  logic [rlht_pkg::HEAD_W-1:0] heading;

  modport source(output valid, output heading, input ready);
  modport sink(input valid, input heading, output ready);
endinterface

[rtl/core/rlht_cfg_if.sv]
// Configuration write channel of the heading tracker: register index and data.
// Depends on rlht_pkg for field widths.
`timescale 1ns / 1ps

interface rlht_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rlht_pkg::CFG_IDX_W-1:0]  idx;
  logic [rlht_pkg::CFG_DATA_W-1:0] wdata;

  modport source(output valid, output idx, output wdata, input ready);
  modport sink(input valid, input idx, input wdata, output ready);
endinterface

[rtl/core/rate_limited_heading_tracker_core.sv]
// Rate limited heading tracker: CORDIC bearing, limited turn step, heading register.
// Depends on rlht_pkg, rlht_in_if, rlht_out_if, rlht_cfg_if and assert_macros.svh.
//
// One transaction at a time. After acceptance the shift-add CORDIC unit runs
// CORDIC_STEPS iterations, then bearing, difference, two passes through one
// shared 28x29 multiplier (step = min(diff, rate) * dt / 1000 by reciprocal),
// the step add and a subtract loop that wraps the heading into one turn. The
// result is loaded at the end of the wrap loop, later only while the previous
// result still waits to be taken, and the next input is taken the cycle after;
// the output register holds one result, so a new input is accepted while it
// waits to be taken.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rate_limited_heading_tracker_core (
  input  logic       clk,
  input  logic       rst_n,
  rlht_in_if.sink    in_ch,
  rlht_out_if.source out_ch,
  rlht_cfg_if.sink   cfg_ch
);

  localparam int COORD_BITS = rlht_pkg::COORD_BITS;
  localparam int XY_W       = rlht_pkg::XY_W;
  localparam int Z_W        = rlht_pkg::Z_W;
  localparam int CNT_W      = rlht_pkg::CNT_W;
  localparam int HEAD_W     = rlht_pkg::HEAD_W;
  localparam int POS_W      = rlht_pkg::POS_W;
  localparam int DT_W       = rlht_pkg::DT_W;
  localparam int RATE_W     = rlht_pkg::RATE_W;
  localparam int BRAW_W     = rlht_pkg::BRAW_W;
  localparam int MUL_A_W    = rlht_pkg::MUL_A_W;
  localparam int MUL_B_W    = rlht_pkg::MUL_B_W;
  localparam int PROD_W     = rlht_pkg::PROD_W;
  localparam int STEP_W     = rlht_pkg::STEP_W;
  localparam int ACC_W      = rlht_pkg::ACC_W;
  localparam int VEC_SHIFT  = rlht_pkg::VEC_SHIFT;
  localparam int EXT_W      = XY_W - COORD_BITS - 1 - VEC_SHIFT;

  localparam logic [CNT_W-1:0]       CNT_LAST   = CNT_W'(rlht_pkg::NUM_IT - 1);
  localparam logic signed [Z_W-1:0]  Z_HALF_C   = Z_W'(rlht_pkg::Z_HALF);
  localparam logic signed [Z_W-1:0]  Z_FULL_C   = Z_W'(rlht_pkg::Z_FULL);
  localparam logic [Z_W-1:0]         Z_RND_C    = Z_W'(rlht_pkg::Z_RND);
  localparam logic [BRAW_W-1:0]      B_FULL     = BRAW_W'(rlht_pkg::FULL_TURN);
  localparam logic [HEAD_W:0]        HALF_E     = (HEAD_W + 1)'(rlht_pkg::HALF_TURN);
  localparam logic [HEAD_W-1:0]      HEAD_FULL  = HEAD_W'(rlht_pkg::FULL_TURN);
  localparam logic [MUL_B_W-1:0]     RECIP_C    = MUL_B_W'(rlht_pkg::RECIP);
  localparam logic [ACC_W-1:0]       ACC_FULL   = ACC_W'(rlht_pkg::FULL_TURN);
  localparam logic [ACC_W-1:0]       ACC_BIAS   = ACC_W'(rlht_pkg::WRAP_BIAS);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ROT  = 8'b0000_0010,
    ST_BEAR = 8'b0000_0100,
    ST_DIFF = 8'b0000_1000,
    ST_MUL1 = 8'b0001_0000,
    ST_MUL2 = 8'b0010_0000,
    ST_STEP = 8'b0100_0000,
    ST_WRAP = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [HEAD_W-1:0]        current_heading_r, current_heading_nxt;
  logic [POS_W-1:0]         center_x_r, center_x_nxt;
  logic [POS_W-1:0]         center_y_r, center_y_nxt;
  logic [RATE_W-1:0]        max_rate_r, max_rate_nxt;

  logic signed [XY_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic                     zero_r, zero_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic [HEAD_W-1:0]        bear_r, bear_nxt;
  logic [HEAD_W-1:0]        mina_r, mina_nxt;
  logic                     up_r, up_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;

  logic                     in_fire, cfg_fire;

  // load
  logic [COORD_BITS-1:0]    tx_m, ty_m, cx_m, cy_m;
  logic signed [COORD_BITS:0] dx, dy, dxn, dyn, dx_sel, dy_sel;
  logic signed [XY_W-1:0]   x_ld, y_ld;

  // CORDIC iteration
  logic signed [XY_W-1:0]   xs, ys, x_rot, y_rot;
  logic signed [Z_W-1:0]    atan_s, z_rot;

  // bearing
  logic signed [Z_W-1:0]    z_pos;
  logic [Z_W-1:0]           z_rnd;
  logic [BRAW_W-1:0]        b_raw, b_fold;

  // difference and direction
  logic [HEAD_W:0]          c_e, h_e;
  logic [HEAD_W-1:0]        diff, lim;
  logic                     up_v;

  // shared multiplier
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [STEP_W-1:0]        step_v;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.heading = current_heading_r;

  // load: difference vector, turned by 180 degrees when the target is left
  assign tx_m = COORD_BITS'({{COORD_BITS{1'b0}}, in_ch.target_x});
  assign ty_m = COORD_BITS'({{COORD_BITS{1'b0}}, in_ch.target_y});
  assign cx_m = COORD_BITS'({{COORD_BITS{1'b0}}, center_x_r});
  assign cy_m = COORD_BITS'({{COORD_BITS{1'b0}}, center_y_r});
  assign dx   = signed'({1'b0, tx_m}) - signed'({1'b0, cx_m});
  assign dy   = signed'({1'b0, ty_m}) - signed'({1'b0, cy_m});
  assign dxn  = signed'({1'b0, cx_m}) - signed'({1'b0, tx_m});
  assign dyn  = signed'({1'b0, cy_m}) - signed'({1'b0, ty_m});
  assign dx_sel = dx[COORD_BITS] ? dxn : dx;
  assign dy_sel = dx[COORD_BITS] ? dyn : dy;
  assign x_ld = {{EXT_W{dx_sel[COORD_BITS]}}, dx_sel, {VEC_SHIFT{1'b0}}};
  assign y_ld = {{EXT_W{dy_sel[COORD_BITS]}}, dy_sel, {VEC_SHIFT{1'b0}}};

  // one CORDIC vectoring iteration
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_s = signed'(Z_W'(rlht_pkg::atan_entry(rlht_pkg::TAB_IDX_W'(cnt_r))));
  assign x_rot  = y_r[XY_W-1] ? x_r - ys : x_r + ys;
  assign y_rot  = y_r[XY_W-1] ? y_r + xs : y_r - xs;
  assign z_rot  = y_r[XY_W-1] ? z_r - atan_s : z_r + atan_s;

  // angle to 1/128 degree, halves up, full turn folded to zero
  assign z_pos  = z_r[Z_W-1] ? z_r + Z_FULL_C : z_r;
  assign z_rnd  = unsigned'(z_pos) + Z_RND_C;
  assign b_raw  = z_rnd[rlht_pkg::RND_SHIFT +: BRAW_W];
  assign b_fold = (b_raw >= B_FULL) ? b_raw - B_FULL : b_raw;

  assign c_e  = {1'b0, bear_r};
  assign h_e  = {1'b0, current_heading_r};
  assign diff = (bear_r > current_heading_r) ? bear_r - current_heading_r
                                             : current_heading_r - bear_r;
  assign lim  = HEAD_W'({max_rate_r, {rlht_pkg::FRAC_BITS{1'b0}}});
  assign up_v = (bear_r > current_heading_r) ? !(c_e > h_e + HALF_E)
                                             : (c_e + HALF_E < h_e);

  assign mul_a  = (state_r == ST_MUL2) ? prod_r[MUL_A_W-1:0] : MUL_A_W'(mina_r);
  assign mul_b  = (state_r == ST_MUL2) ? RECIP_C : MUL_B_W'(dt_r);
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign step_v = prod_r[rlht_pkg::RECIP_SHIFT +: STEP_W];

  always_comb begin
    state_nxt           = state_r;
    cnt_nxt             = cnt_r;
    x_nxt               = x_r;
    y_nxt               = y_r;
    z_nxt               = z_r;
    zero_nxt            = zero_r;
    dt_nxt              = dt_r;
    bear_nxt            = bear_r;
    mina_nxt            = mina_r;
    up_nxt              = up_r;
    prod_nxt            = prod_r;
    acc_nxt             = acc_r;
    current_heading_nxt = current_heading_r;
    out_valid_nxt       = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt     = x_ld;
          y_nxt     = y_ld;
          z_nxt     = dx[COORD_BITS] ? Z_HALF_C : '0;
          zero_nxt  = (dx == '0) && (dy == '0);
          dt_nxt    = in_ch.elapsed_ms;
          cnt_nxt   = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        x_nxt   = x_rot;
        y_nxt   = y_rot;
        z_nxt   = z_rot;
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_BEAR;
        end
      end
      ST_BEAR: begin
        bear_nxt  = zero_r ? '0 : HEAD_W'(b_fold);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        mina_nxt  = (diff < lim) ? diff : lim;
        up_nxt    = up_v;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        acc_nxt   = up_r ? ACC_W'(current_heading_r) + ACC_W'(step_v)
                         : ACC_W'(current_heading_r) + ACC_BIAS - ACC_W'(step_v);
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (acc_r >= ACC_FULL) begin
          acc_nxt = acc_r - ACC_FULL;
        end else if (!out_valid_r || out_ch.ready) begin
          current_heading_nxt = acc_r[HEAD_W-1:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    max_rate_nxt = max_rate_r;
    if (cfg_fire) begin
      unique case (rlht_pkg::reg_idx_t'(cfg_ch.idx))
        rlht_pkg::REG_CENTER_X: center_x_nxt = cfg_ch.wdata[POS_W-1:0];
        rlht_pkg::REG_CENTER_Y: center_y_nxt = cfg_ch.wdata[POS_W-1:0];
        rlht_pkg::REG_MAX_RATE: max_rate_nxt = cfg_ch.wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      cnt_r             <= '0;
      out_valid_r       <= 1'b0;
      current_heading_r <= '0;
      center_x_r        <= POS_W'(rlht_pkg::CENTER_X_RST);
      center_y_r        <= POS_W'(rlht_pkg::CENTER_Y_RST);
      max_rate_r        <= RATE_W'(rlht_pkg::MAX_RATE_RST);
    end else begin
      state_r           <= state_nxt;
      cnt_r             <= cnt_nxt;
      out_valid_r       <= out_valid_nxt;
      current_heading_r <= current_heading_nxt;
      center_x_r        <= center_x_nxt;
      center_y_r        <= center_y_nxt;
      max_rate_r        <= max_rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
    dt_r   <= dt_nxt;
    bear_r <= bear_nxt;
    mina_r <= mina_nxt;
    up_r   <= up_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  `RLHT_ASSERT(a_heading_range, current_heading_r < HEAD_FULL, "heading outside one turn")
  `RLHT_ASSERT_NXT(a_start_rot, in_fire, state_r == ST_ROT, "accepted input did not start CORDIC")
  `RLHT_ASSERT(a_cnt_range, (state_r == ST_ROT) |-> (cnt_r <= CNT_LAST), "CORDIC count overrun")
  `RLHT_ASSERT_NXT(a_hold_pending, (state_r == ST_WRAP) && out_valid_r && !out_ch.ready, $stable(current_heading_r) && out_valid_r, "pending result overwritten")

endmodule
